// ===== hdl/adsr_envelope_gain_top_defines.svh =====
// Assertion helpers for the envelope gain block.
// Both expect signals named clock and reset in the scope of use.
`ifndef ADSR_ENVELOPE_GAIN_TOP_DEFINES_SVH
`define ADSR_ENVELOPE_GAIN_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ADSRG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ADSRG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/adsrg_pkg.sv =====
`default_nettype none

package adsrg_pkg;

   localparam int TIME_BITS_DEF = 24;

   localparam int SAMPLE_BITS   = 16;
   localparam int LEN_BITS      = 24;
   localparam int LEVEL_BITS    = 15;
   localparam int GAIN_BITS     = 15;
   localparam int FRAC_BITS     = 14;
   localparam int QUO_BITS      = 15;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   localparam logic [CSR_IDX_BITS-1:0] REG_ATTACK_END    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DECAY_END     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SUSTAIN_LEVEL = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_RELEASE_LEN   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_NOTE_LEN      = 3'd4;

   localparam logic [LEN_BITS-1:0]   ATTACK_END_RST    = 24'd4410;
   localparam logic [LEN_BITS-1:0]   DECAY_END_RST     = 24'd2205;
   localparam logic [LEVEL_BITS-1:0] SUSTAIN_LEVEL_RST = 15'd16384;
   localparam logic [LEN_BITS-1:0]   RELEASE_LEN_RST   = 24'd4410;
   localparam logic [LEN_BITS-1:0]   NOTE_LEN_RST      = 24'd44100;

   localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 15'd16384;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_DIV,
      ST_GAIN,
      ST_APPLY,
      ST_SAT,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      SEG_ATTACK,
      SEG_DECAY_UP,
      SEG_DECAY_DOWN,
      SEG_RELEASE,
      SEG_FLAT
   } seg_type;

endpackage

`default_nettype wire

// ===== hdl/adsrg_if.sv =====
`default_nettype none

interface adsrg_req_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [adsrg_pkg::SAMPLE_BITS-1:0]    sample_in;
   logic                                        restart;

   modport source (output valid, output sample_in, output restart, input ready);
   modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface adsrg_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [adsrg_pkg::SAMPLE_BITS-1:0]    sample_out;
   logic                                        still_active;

   modport source (output valid, output sample_out, output still_active, input ready);
   modport sink   (input valid, input sample_out, input still_active, output ready);
endinterface

`default_nettype wire

// ===== hdl/adsr_envelope_gain_top.sv =====
// Channel    Dir  Payload
// req_chan   in   sample_in (s16), restart (1)
// rsp_chan   out  sample_out (s16), still_active (1)
// csr_*      in   csr_we, csr_index (3), csr_wdata (24)
//
// One item at a time; req ready only while idle.
// Ramp segments (attack, decay, release) step through DECODE, MUL, DIV, GAIN,
// APPLY, SAT and OUT, with the 15-step restoring divider forming the gain; flat
// sustain or past-note items go from DECODE to APPLY. rsp valid holds until taken.
// Reset is synchronous: registers return to defaults, elapsed count clears.
`default_nettype none

module adsr_envelope_gain_top #(
   parameter int TIME_BITS = adsrg_pkg::TIME_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   adsrg_req_if.sink                                 req_chan,
   adsrg_rsp_if.source                               rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [adsrg_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [adsrg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int LEN_BITS   = adsrg_pkg::LEN_BITS;
   localparam int GAIN_BITS  = adsrg_pkg::GAIN_BITS;
   localparam int LVL_BITS   = adsrg_pkg::LEVEL_BITS;
   localparam int SMP_BITS   = adsrg_pkg::SAMPLE_BITS;
   localparam int QUO_BITS   = adsrg_pkg::QUO_BITS;
   localparam int FRAC_BITS  = adsrg_pkg::FRAC_BITS;
   localparam int CW         = ((TIME_BITS > LEN_BITS) ? TIME_BITS : LEN_BITS) + 1;
   localparam int CNT_BITS   = $clog2(QUO_BITS);
   localparam int MA_BITS    = SMP_BITS + 1;
   localparam int MB_BITS    = LEN_BITS + 1;
   localparam int MP_BITS    = MA_BITS + MB_BITS;
   localparam int NUM_BITS   = LEN_BITS + QUO_BITS;
   localparam int PROD_BITS  = SMP_BITS + GAIN_BITS;
   localparam int SH_BITS    = PROD_BITS - FRAC_BITS;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   typedef struct packed {
      logic decode;
      logic mul;
      logic div;
      logic gain;
      logic apply;
      logic sat;
   } ctrl_type;

   adsrg_pkg::state_type state_ff, state_in;
   adsrg_pkg::seg_type   seg_ff, seg_in;
   ctrl_type             ctrl;

   logic [LEN_BITS-1:0]  attack_end_ff, decay_end_ff, release_len_ff, note_len_ff;
   logic [LVL_BITS-1:0]  sustain_ff;

   logic [TIME_BITS-1:0] elapsed_ff, t_ff, t_cur, t_inc;
   logic                 active_ff, active_in;
   logic signed [SMP_BITS-1:0] sample_ff;

   logic [CW-1:0]        t_w;
   logic [GAIN_BITS-1:0] coef_ff, coef_in;
   logic [LEN_BITS-1:0]  mcand_ff, mcand_in;
   logic [LEN_BITS-1:0]  den_ff, den_in;
   logic [GAIN_BITS-1:0] flat_gain;

   logic [LEN_BITS-1:0]  rem_ff;
   logic [QUO_BITS-1:0]  quo_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [LEN_BITS:0]    trial;
   logic                 trial_ge;
   logic                 div_last;

   logic [GAIN_BITS-1:0] gain_ff, gain_in;

   logic signed [MA_BITS-1:0]   mul_a;
   logic signed [MB_BITS-1:0]   mul_b;
   logic signed [MP_BITS-1:0]   mul_p;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [SH_BITS-1:0]   shifted;
   logic signed [SMP_BITS-1:0]  sat_val, out_sample_ff;

   logic req_fire;

   assign req_fire = req_chan.valid & req_chan.ready;

   // elapsed time for this item and the saturating count after it
   assign t_cur     = req_chan.restart ? '0 : elapsed_ff;
   assign t_inc     = (t_cur == TIME_MAX) ? t_cur : t_cur + TIME_BITS'(1);
   assign active_in = CW'(t_inc) < CW'(note_len_ff);

   // segment decode and operands for the ramp quotient
   assign t_w = CW'(t_ff);

   always_comb begin
      seg_in    = adsrg_pkg::SEG_FLAT;
      coef_in   = adsrg_pkg::UNITY_GAIN;
      mcand_in  = t_w[LEN_BITS-1:0];
      den_in    = attack_end_ff;
      flat_gain = sustain_ff;
      priority if (t_w < CW'(attack_end_ff)) begin
         seg_in = adsrg_pkg::SEG_ATTACK;
      end else if (t_w < CW'(decay_end_ff)) begin
         mcand_in = t_w[LEN_BITS-1:0] - attack_end_ff;
         den_in   = decay_end_ff - attack_end_ff;
         if (sustain_ff >= adsrg_pkg::UNITY_GAIN) begin
            seg_in  = adsrg_pkg::SEG_DECAY_UP;
            coef_in = sustain_ff - adsrg_pkg::UNITY_GAIN;
         end else begin
            seg_in  = adsrg_pkg::SEG_DECAY_DOWN;
            coef_in = adsrg_pkg::UNITY_GAIN - sustain_ff;
         end
      end else if ((release_len_ff != '0) &&
                   ((t_w + CW'(release_len_ff)) > CW'(note_len_ff))) begin
         if (t_w >= CW'(note_len_ff)) begin
            flat_gain = '0;
         end else begin
            seg_in   = adsrg_pkg::SEG_RELEASE;
            coef_in  = (sustain_ff == '0) ? adsrg_pkg::UNITY_GAIN : sustain_ff;
            mcand_in = note_len_ff - t_w[LEN_BITS-1:0];
            den_in   = release_len_ff;
         end
      end else begin
         flat_gain = sustain_ff;
      end
   end

   // shared multiplier: ramp numerator, then sample times gain
   always_comb begin
      if (ctrl.apply) begin
         mul_a = MA_BITS'(sample_ff);
         mul_b = MB_BITS'(gain_ff);
      end else begin
         mul_a = MA_BITS'(coef_ff);
         mul_b = MB_BITS'(mcand_ff);
      end
   end

   assign mul_p = mul_a * mul_b;

   // one restoring divide step per cycle
   assign trial    = {rem_ff, quo_ff[QUO_BITS-1]};
   assign trial_ge = trial >= {1'b0, den_ff};
   assign div_last = cnt_ff == CNT_BITS'(QUO_BITS - 1);

   always_comb begin
      unique case (seg_ff)
         adsrg_pkg::SEG_ATTACK,
         adsrg_pkg::SEG_RELEASE:    gain_in = quo_ff;
         adsrg_pkg::SEG_DECAY_UP:   gain_in = adsrg_pkg::UNITY_GAIN + quo_ff;
         adsrg_pkg::SEG_DECAY_DOWN: gain_in = adsrg_pkg::UNITY_GAIN - quo_ff;
         default:                   gain_in = gain_ff;
      endcase
   end

   // floor shift by the fraction bits, then clamp to the sample range
   assign shifted = prod_ff[PROD_BITS-1:FRAC_BITS];

   always_comb begin
      if (shifted[SH_BITS-1] != shifted[SMP_BITS-1]) begin
         sat_val = {shifted[SH_BITS-1], {(SMP_BITS-1){~shifted[SH_BITS-1]}}};
      end else begin
         sat_val = shifted[SMP_BITS-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         adsrg_pkg::ST_IDLE: begin
            if (req_fire) state_in = adsrg_pkg::ST_DECODE;
         end
         adsrg_pkg::ST_DECODE: begin
            if (seg_in == adsrg_pkg::SEG_FLAT) state_in = adsrg_pkg::ST_APPLY;
            else state_in = adsrg_pkg::ST_MUL;
         end
         adsrg_pkg::ST_MUL:   state_in = adsrg_pkg::ST_DIV;
         adsrg_pkg::ST_DIV: begin
            if (div_last) state_in = adsrg_pkg::ST_GAIN;
         end
         adsrg_pkg::ST_GAIN:  state_in = adsrg_pkg::ST_APPLY;
         adsrg_pkg::ST_APPLY: state_in = adsrg_pkg::ST_SAT;
         adsrg_pkg::ST_SAT:   state_in = adsrg_pkg::ST_OUT;
         adsrg_pkg::ST_OUT: begin
            if (rsp_chan.ready) state_in = adsrg_pkg::ST_IDLE;
         end
         default: state_in = adsrg_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ctrl.decode    = state_ff == adsrg_pkg::ST_DECODE;
      ctrl.mul       = state_ff == adsrg_pkg::ST_MUL;
      ctrl.div       = state_ff == adsrg_pkg::ST_DIV;
      ctrl.gain      = state_ff == adsrg_pkg::ST_GAIN;
      ctrl.apply     = state_ff == adsrg_pkg::ST_APPLY;
      ctrl.sat       = state_ff == adsrg_pkg::ST_SAT;
      req_chan.ready = state_ff == adsrg_pkg::ST_IDLE;
      rsp_chan.valid = state_ff == adsrg_pkg::ST_OUT;
   end

   assign rsp_chan.sample_out   = out_sample_ff;
   assign rsp_chan.still_active = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= adsrg_pkg::ST_IDLE;
         elapsed_ff     <= '0;
         attack_end_ff  <= adsrg_pkg::ATTACK_END_RST;
         decay_end_ff   <= adsrg_pkg::DECAY_END_RST;
         sustain_ff     <= adsrg_pkg::SUSTAIN_LEVEL_RST;
         release_len_ff <= adsrg_pkg::RELEASE_LEN_RST;
         note_len_ff    <= adsrg_pkg::NOTE_LEN_RST;
      end else begin
         state_ff <= state_in;
         if (req_fire) elapsed_ff <= t_inc;
         if (csr_we) begin
            unique case (csr_index)
               adsrg_pkg::REG_ATTACK_END:    attack_end_ff  <= csr_wdata[LEN_BITS-1:0];
               adsrg_pkg::REG_DECAY_END:     decay_end_ff   <= csr_wdata[LEN_BITS-1:0];
               adsrg_pkg::REG_SUSTAIN_LEVEL: sustain_ff     <= csr_wdata[LVL_BITS-1:0];
               adsrg_pkg::REG_RELEASE_LEN:   release_len_ff <= csr_wdata[LEN_BITS-1:0];
               adsrg_pkg::REG_NOTE_LEN:      note_len_ff    <= csr_wdata[LEN_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         t_ff      <= t_cur;
         sample_ff <= req_chan.sample_in;
         active_ff <= active_in;
      end
      if (ctrl.decode) begin
         seg_ff   <= seg_in;
         coef_ff  <= coef_in;
         mcand_ff <= mcand_in;
         den_ff   <= den_in;
         gain_ff  <= flat_gain;
      end
      if (ctrl.mul) begin
         // quotient fits QUO_BITS, so the upper part already sits below the divisor
         rem_ff <= mul_p[NUM_BITS-1:QUO_BITS];
         quo_ff <= mul_p[QUO_BITS-1:0];
         cnt_ff <= '0;
      end
      if (ctrl.div) begin
         rem_ff <= trial_ge ? LEN_BITS'(trial - {1'b0, den_ff}) : trial[LEN_BITS-1:0];
         quo_ff <= {quo_ff[QUO_BITS-2:0], trial_ge};
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
      if (ctrl.gain) gain_ff <= gain_in;
      if (ctrl.apply) prod_ff <= mul_p[PROD_BITS-1:0];
      if (ctrl.sat) out_sample_ff <= sat_val;
   end

endmodule

`default_nettype wire

// ===== hdl/adsrg_checker.sv =====
`default_nettype none
`include "adsr_envelope_gain_top_defines.svh"

module adsrg_checker (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic                                    req_valid,
   input wire logic                                    req_ready,
   input wire logic                                    rsp_valid,
   input wire logic                                    rsp_ready,
   input wire logic signed [adsrg_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input wire logic                                    rsp_still_active
);

   // one item in flight: no new item while a result is on offer
   `ADSRG_ASSERT_SAME(a_busy_while_rsp, rsp_valid, !req_ready, "req ready with result pending")

   // an accepted item blocks input and does not return its result straight away
   `ADSRG_ASSERT_NEXT(a_accept_blocks, req_valid && req_ready, !req_ready && !rsp_valid, "item accept did not block")

   // once the result is taken the block is idle again
   `ADSRG_ASSERT_NEXT(a_rsp_frees, rsp_valid && rsp_ready, !rsp_valid && req_ready, "block not idle after result")

   `ADSRG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out) && $stable(rsp_still_active), "stalled result changed")

endmodule

bind adsr_envelope_gain_top adsrg_checker u_adsrg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_sample_out   (rsp_chan.sample_out),
   .rsp_still_active (rsp_chan.still_active)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int SAMPLE_BITS   = adsrg_pkg::SAMPLE_BITS;
   localparam int LEN_BITS      = adsrg_pkg::LEN_BITS;
   localparam int LEVEL_BITS    = adsrg_pkg::LEVEL_BITS;
   localparam int FRAC_BITS     = adsrg_pkg::FRAC_BITS;
   localparam int CSR_IDX_BITS  = adsrg_pkg::CSR_IDX_BITS;
   localparam int CSR_DATA_BITS = adsrg_pkg::CSR_DATA_BITS;
   localparam logic [adsrg_pkg::GAIN_BITS-1:0] UNITY_GAIN = adsrg_pkg::UNITY_GAIN;

   // Time counter width for the block under test.
   localparam int TB_TIME_BITS = 12;
   localparam longint unsigned ELAPSED_MAX = (64'd1 << TB_TIME_BITS) - 1;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 30;
   localparam int PRINT_LIMIT = 50;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER_ITEMS = 200;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 75;
   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
   localparam logic [CSR_IDX_BITS-1:0] IDX_TOP = '1;
   localparam longint SAMPLE_HI = 2 ** (SAMPLE_BITS - 1) - 1;
   localparam longint SAMPLE_LO = -(2 ** (SAMPLE_BITS - 1));

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   restart;
      logic [7:0]             gap;
   } sample_item_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   active;
   } gained_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   logic                            drv_valid = 1'b0;
   logic signed [SAMPLE_BITS-1:0]   drv_sample = '0;
   logic                            drv_restart = 1'b0;
   logic                            mon_ready = 1'b0;
   logic                            csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]         csr_index = '0;
   logic [CSR_DATA_BITS-1:0]        csr_wdata = '0;

   adsrg_req_if req_if ();
   adsrg_rsp_if rsp_if ();

   assign req_if.valid     = drv_valid;
   assign req_if.sample_in = drv_sample;
   assign req_if.restart   = drv_restart;
   assign rsp_if.ready     = mon_ready;

   adsr_envelope_gain_top #(
      .TIME_BITS(TB_TIME_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Envelope settings and elapsed count as the block should hold them.
   logic [LEN_BITS-1:0]   atk_end = adsrg_pkg::ATTACK_END_RST;
   logic [LEN_BITS-1:0]   dec_end = adsrg_pkg::DECAY_END_RST;
   logic [LEVEL_BITS-1:0] sus_level = adsrg_pkg::SUSTAIN_LEVEL_RST;
   logic [LEN_BITS-1:0]   rel_len = adsrg_pkg::RELEASE_LEN_RST;
   logic [LEN_BITS-1:0]   note_len = adsrg_pkg::NOTE_LEN_RST;
   longint unsigned       elapsed = 0;

   sample_item_type samples_to_send[$];
   gained_type      gained_due[$];
   int           errors = 0;
   int           cycles = 0;
   int           accepted = 0;
   logic         hold_rsp = 1'b0;
   logic         rsp_quiet = 1'b0;

   task automatic report_mismatch(string what);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic int unsigned draw_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint unsigned envelope_at(longint unsigned t);
      longint unsigned atk, dec, sus, rel, note, lvl;
      atk  = atk_end;
      dec  = dec_end;
      sus  = sus_level;
      rel  = rel_len;
      note = note_len;
      if (t < atk)
         return (t * UNITY_GAIN) / atk;
      if (t < dec) begin
         if (sus >= UNITY_GAIN)
            return UNITY_GAIN + ((sus - UNITY_GAIN) * (t - atk)) / (dec - atk);
         return UNITY_GAIN - ((UNITY_GAIN - sus) * (t - atk)) / (dec - atk);
      end
      if (rel != 0 && t + rel > note) begin
         lvl = (sus == 0) ? UNITY_GAIN : sus;
         if (t >= note)
            return 0;
         return (lvl * (note - t)) / rel;
      end
      return sus;
   endfunction

   // Floor of the product with the unsigned Q1.14 gain, clamped to the sample range.
   function automatic logic [SAMPLE_BITS-1:0] scale_sample(logic signed [SAMPLE_BITS-1:0] x,
                                                          longint unsigned g);
      longint p, q;
      p = longint'(x) * longint'(g);
      q = p >>> FRAC_BITS;
      if (q > SAMPLE_HI)
         q = SAMPLE_HI;
      if (q < SAMPLE_LO)
         q = SAMPLE_LO;
      return q[SAMPLE_BITS-1:0];
   endfunction

   function automatic gained_type apply_envelope(sample_item_type it);
      gained_type      r;
      longint unsigned t;
      if (it.restart)
         elapsed = 0;
      t = elapsed;
      r.sample = scale_sample(it.sample, envelope_at(t));
      if (t < ELAPSED_MAX)
         t++;
      elapsed = t;
      r.active = (t < note_len);
      return r;
   endfunction

   function automatic void apply_reg_write(logic [CSR_IDX_BITS-1:0] idx,
                                           logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         adsrg_pkg::REG_ATTACK_END:    atk_end = data[LEN_BITS-1:0];
         adsrg_pkg::REG_DECAY_END:     dec_end = data[LEN_BITS-1:0];
         adsrg_pkg::REG_SUSTAIN_LEVEL: sus_level = data[LEVEL_BITS-1:0];
         adsrg_pkg::REG_RELEASE_LEN:   rel_len = data[LEN_BITS-1:0];
         adsrg_pkg::REG_NOTE_LEN:      note_len = data[LEN_BITS-1:0];
         default: ;
      endcase
   endfunction

   // Sender: present the head of the queue after its gap, pop it on accept.
   int unsigned gap_left = 0;
   logic        gap_armed = 1'b0;

   always @(posedge clock) begin
      sample_item_type head;
      logic            next_valid;
      if (reset) begin
         drv_valid <= 1'b0;
         gap_armed = 1'b0;
      end else begin
         next_valid = drv_valid;
         if (drv_valid && req_if.ready) begin
            gained_due.push_back(apply_envelope(samples_to_send.pop_front()));
            accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid && samples_to_send.size() > 0) begin
            head = samples_to_send[0];
            if (!gap_armed) begin
               gap_left = head.gap;
               gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               next_valid = 1'b1;
               gap_armed = 1'b0;
               drv_sample <= head.sample;
               drv_restart <= head.restart;
            end
         end
         drv_valid <= next_valid;
      end
   end

   // Receiver: compare each item taken with the oldest prediction.
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      gained_type want;
      if (reset) begin
         mon_ready <= 1'b0;
      end else begin
         if (rsp_if.valid && mon_ready) begin
            if (gained_due.size() == 0) begin
               report_mismatch($sformatf("item with nothing pending: sample_out=%0d active=%0b",
                                         rsp_if.sample_out, rsp_if.still_active));
            end else begin
               want = gained_due.pop_front();
               if (rsp_if.sample_out !== want.sample)
                  report_mismatch($sformatf("sample_out %0d, want %0d", rsp_if.sample_out,
                                            $signed(want.sample)));
               if (rsp_if.still_active !== want.active)
                  report_mismatch($sformatf("still_active %0b, want %0b",
                                            rsp_if.still_active, want.active));
            end
            stall_left = rsp_quiet ? 0 : draw_gap();
         end
         if (hold_rsp) begin
            mon_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            mon_ready <= 1'b0;
         end else begin
            mon_ready <= 1'b1;
         end
      end
   end

   // Long receiver stall while the sender keeps offering items.
   initial begin
      while (accepted < HOLD_AFTER_ITEMS)
         @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic queue_sample(logic [SAMPLE_BITS-1:0] s, logic r, int unsigned g);
      sample_item_type it;
      it.sample = s;
      it.restart = r;
      it.gap = g[7:0];
      samples_to_send.push_back(it);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_reg_write(idx, data);
   endtask

   task automatic set_envelope(logic [CSR_DATA_BITS-1:0] atk, logic [CSR_DATA_BITS-1:0] dec,
                               logic [CSR_DATA_BITS-1:0] sus, logic [CSR_DATA_BITS-1:0] rel,
                               logic [CSR_DATA_BITS-1:0] note, logic stray);
      write_reg(adsrg_pkg::REG_ATTACK_END, atk);
      write_reg(adsrg_pkg::REG_DECAY_END, dec);
      write_reg(adsrg_pkg::REG_SUSTAIN_LEVEL, sus);
      write_reg(adsrg_pkg::REG_RELEASE_LEN, rel);
      write_reg(adsrg_pkg::REG_NOTE_LEN, note);
      if (stray)
         write_reg(CSR_IDX_BITS'($urandom_range(adsrg_pkg::REG_NOTE_LEN + 1, IDX_TOP)),
                   CSR_DATA_BITS'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (samples_to_send.size() != 0 || gained_due.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_len(int unsigned top);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return LEN_MAX;
      return CSR_DATA_BITS'($urandom_range(1, top));
   endfunction

   // Random upper bits must be dropped by the block.
   function automatic logic [CSR_DATA_BITS-1:0] pick_level();
      logic [CSR_DATA_BITS-1:0] word;
      word = CSR_DATA_BITS'($urandom);
      case ($urandom_range(0, 3))
         0: word[LEVEL_BITS-1:0] = '0;
         1: word[LEVEL_BITS-1:0] = UNITY_GAIN;
         2: word[LEVEL_BITS-1:0] = LEVEL_MAX;
         default: ;
      endcase
      return word;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_BITS'(SAMPLE_HI);
         1: return SAMPLE_BITS'(SAMPLE_LO);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Notes: runs of samples, most opening with a restart, with a stray restart now and then.
   task automatic queue_notes(int unsigned count, logic quiet);
      int unsigned left, run, k;
      left = count;
      while (left > 0) begin
         run = $urandom_range(4, 56);
         if (run > left)
            run = left;
         for (k = 0; k < run; k++)
            queue_sample(pick_sample(),
                         (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0),
                         quiet ? 0 : draw_gap());
         left -= run;
      end
   endtask

   initial begin
      int k;
      int p;
      logic quiet;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: attack ramp start, decay end before attack end.
      queue_sample(SAMPLE_BITS'(SAMPLE_HI), 1'b1, 0);
      queue_sample(SAMPLE_BITS'(SAMPLE_LO), 1'b0, 1);
      queue_sample('0, 1'b0, 0);
      queue_sample('1, 1'b0, 2);
      queue_sample(SAMPLE_BITS'(1), 1'b0, 0);
      wait_drained();

      // Sustain above unity with upper junk bits: every segment, clamped products.
      set_envelope(4, 8, LEN_MAX, 3, 12, 1'b0);
      for (k = 0; k < 14; k++)
         queue_sample((k % 2 == 0) ? SAMPLE_BITS'(SAMPLE_HI) : SAMPLE_BITS'(SAMPLE_LO),
                      k == 0, k % 3);
      wait_drained();

      // Zero sustain, release ramp from unity, past note end; stray index write.
      set_envelope(0, 2, 0, 2, 4, 1'b1);
      for (k = 0; k < 6; k++)
         queue_sample((k % 2 == 0) ? SAMPLE_BITS'(SAMPLE_LO) : SAMPLE_BITS'(SAMPLE_HI),
                      k == 0, 0);
      wait_drained();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         quiet = (p % 4 == 3);
         rsp_quiet <= quiet;
         if (p == 0)
            set_envelope(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, 1'b1);
         else if (p == 1)
            set_envelope(0, 0, 0, 0, 0, 1'b1);
         else
            set_envelope(pick_len(16), pick_len(32), pick_level(), pick_len(16), pick_len(48),
                         $urandom_range(0, 1));
         queue_notes(PHASE_ITEMS, quiet);
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/adsrg_pkg.sv
hdl/adsrg_if.sv
hdl/adsr_envelope_gain_top.sv
hdl/adsrg_checker.sv
test/tb_top.sv
